[hw/rtl/bsel_pkg.sv]
// Shared types, codes and constants of the backend selector.
package bsel_pkg;

	localparam int SLOT_FIELD_W   = 4;
	localparam int WEIGHT_FIELD_W = 8;
	localparam int CONN_FIELD_W   = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;
	localparam int LIMIT_W        = 16;
	localparam int RR_W           = 32;

	localparam logic OP_SELECT = 1'b0;
	localparam logic OP_WRITE  = 1'b1;

	localparam logic MODE_WRR = 1'b0;
	localparam logic MODE_LC  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ALGORITHM_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONNECTION_LIMIT = 2'd1;

	typedef struct packed {
		logic                      op;
		logic [SLOT_FIELD_W-1:0]   slot;
		logic                      valid_req;
		logic                      healthy;
		logic [WEIGHT_FIELD_W-1:0] weight;
		logic [CONN_FIELD_W-1:0]   connections;
	} req_t;

	typedef struct packed {
		logic                    found;
		logic [SLOT_FIELD_W-1:0] chosen_slot;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_FIND,
		ST_LC_RD,
		ST_LC_MA,
		ST_LC_MB,
		ST_LC_CMP,
		ST_FIN
	} state_t;

endpackage

[hw/rtl/bsel_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bsel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/bsel_div.sv]
// Bit-serial restoring divider that returns the remainder, one bit per cycle.
module bsel_div #(
	parameter int DIVIDEND_W = 32,
	parameter int DIVISOR_W  = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVISOR_W-1:0]  remainder
);

	localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	// shift in the next dividend bit, subtract when it fits
	assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
	assign ge      = (shifted >= {1'b0, divisor});
	assign diff    = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= quo_q << 1;
			rem_q <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

[hw/rtl/backend_selector.sv]
// Backend selector top level: slot table, sequencer and selection datapath.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  req     | req_valid / req_ready  | bsel_pkg::req_t: op, slot, entry fields
//  rsp     | rsp_valid / rsp_ready  | bsel_pkg::rsp_t: found, chosen_slot
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
// One request at a time. A write request goes straight to the finish state. A
// round-robin select makes one table scan for the eligible weight total, a
// pass through the bit-serial remainder unit (32 bit steps), and a second
// scan up to the picked slot. A select with no eligible slot or a zero
// weight total ends after the first scan. A least-connections select takes
// LC_RD and LC_MA for each slot, plus LC_MB and LC_CMP when the single shared
// multiplier is used twice to compare that slot against the current pick.
// Reset clears the valid marks, config registers and round-robin counter.
// A pending response holds; the block still accepts a request and finishes it
// into the response register once that register is free.
module backend_selector #(
	parameter int NUM_SLOTS   = 16,
	parameter int WEIGHT_BITS = 8,
	parameter int CONN_BITS   = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  bsel_pkg::req_t                     req,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output bsel_pkg::rsp_t                     rsp,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bsel_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bsel_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int SLOT_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W    = $clog2(NUM_SLOTS + 1);
	localparam int ENTRY_W  = 1 + WEIGHT_BITS + CONN_BITS;
	localparam int TOT_W    = WEIGHT_BITS + SLOT_W;
	localparam int PROD_W   = CONN_BITS + WEIGHT_BITS;
	localparam int CMP_W    = (CONN_BITS > bsel_pkg::LIMIT_W) ? CONN_BITS : bsel_pkg::LIMIT_W;

	bsel_pkg::state_t state_q, state_d;

	// configuration
	logic                         mode_q;
	logic [bsel_pkg::LIMIT_W-1:0] limit_q;

	// slot table: valid marks in flops, the rest in RAM
	logic [NUM_SLOTS-1:0] entry_valid_q;
	logic                 wr_en;
	logic [SLOT_W-1:0]    wr_addr;
	logic [ENTRY_W-1:0]   wr_data;
	logic                 rd_en;
	logic [ENTRY_W-1:0]   rd_data;

	// scan pipeline
	logic [CNT_W-1:0]  iss_q;
	logic              act_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic              vld_s1;

	// selection state
	logic                   have_pick_q;
	logic [SLOT_W-1:0]      pick_q;
	logic [WEIGHT_BITS-1:0] pw_q;
	logic [CONN_BITS-1:0]   pc_q;
	logic [TOT_W-1:0]       total_q;
	logic [TOT_W-1:0]       cum_q;
	logic [bsel_pkg::RR_W-1:0] rr_q;
	logic [PROD_W-1:0]      prod_a_q;
	logic [PROD_W-1:0]      prod_b_q;

	// response register
	logic           rsp_valid_q;
	bsel_pkg::rsp_t rsp_q;

	// divider
	logic             div_start;
	logic             div_done;
	logic [TOT_W-1:0] div_rem;

	// evaluation of the slot read back in stage 1
	logic                   cur_healthy;
	logic [WEIGHT_BITS-1:0] cur_w;
	logic [CONN_BITS-1:0]   cur_c;
	logic                   under_limit;
	logic                   elig_s1;
	logic                   last_s1;
	logic [TOT_W-1:0]       total_sum;
	logic [TOT_W-1:0]       cum_sum;
	logic                   scan_end;
	logic                   scan_have;
	logic [TOT_W-1:0]       scan_total;
	logic                   find_hit;
	logic                   lc_take;
	logic                   lc_mul;
	logic                   lc_less;
	logic [CONN_BITS-1:0]   mul_a;
	logic [WEIGHT_BITS-1:0] mul_b;
	logic [PROD_W-1:0]      mul_p;
	logic                   accept;
	logic                   rsp_load;

	assign accept = req_valid && req_ready;

	assign cur_healthy = rd_data[ENTRY_W-1];
	assign cur_w       = rd_data[CONN_BITS +: WEIGHT_BITS];
	assign cur_c       = rd_data[CONN_BITS-1:0];

	// a limit of zero means unlimited
	assign under_limit = (limit_q == '0) || (CMP_W'(cur_c) < CMP_W'(limit_q));
	assign elig_s1     = act_s1 && vld_s1 && cur_healthy && under_limit;
	assign last_s1     = (idx_s1 == SLOT_W'(NUM_SLOTS - 1));
	assign total_sum   = total_q + TOT_W'(cur_w);
	assign cum_sum     = cum_q + TOT_W'(cur_w);
	assign scan_end    = (state_q == bsel_pkg::ST_SCAN) && act_s1 && last_s1;
	assign scan_have   = have_pick_q || elig_s1;
	assign scan_total  = elig_s1 ? total_sum : total_q;
	assign find_hit    = elig_s1 && (div_rem < cum_sum);

	// zero weight counts as infinitely loaded
	assign lc_take = elig_s1 && (!have_pick_q || ((cur_w != '0) && (pw_q == '0)));
	assign lc_mul  = elig_s1 && have_pick_q && (cur_w != '0) && (pw_q != '0);
	assign lc_less = (prod_a_q < prod_b_q);

	// shared multiplier: conn_i * w_pick, then conn_pick * w_i
	assign mul_a = (state_q == bsel_pkg::ST_LC_MA) ? cur_c : pc_q;
	assign mul_b = (state_q == bsel_pkg::ST_LC_MA) ? pw_q : cur_w;
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsel_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (req.op == bsel_pkg::OP_WRITE) begin
						state_d = bsel_pkg::ST_FIN;
					end else if (mode_q == bsel_pkg::MODE_LC) begin
						state_d = bsel_pkg::ST_LC_RD;
					end else begin
						state_d = bsel_pkg::ST_SCAN;
					end
				end
			end
			bsel_pkg::ST_SCAN: begin
				if (scan_end) begin
					if (!scan_have || (scan_total == '0)) begin
						state_d = bsel_pkg::ST_FIN;
					end else begin
						state_d = bsel_pkg::ST_DIV;
					end
				end
			end
			bsel_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = bsel_pkg::ST_FIND;
				end
			end
			bsel_pkg::ST_FIND: begin
				if (act_s1 && (find_hit || last_s1)) begin
					state_d = bsel_pkg::ST_FIN;
				end
			end
			bsel_pkg::ST_LC_RD: begin
				state_d = bsel_pkg::ST_LC_MA;
			end
			bsel_pkg::ST_LC_MA: begin
				if (lc_mul) begin
					state_d = bsel_pkg::ST_LC_MB;
				end else if (last_s1) begin
					state_d = bsel_pkg::ST_FIN;
				end else begin
					state_d = bsel_pkg::ST_LC_RD;
				end
			end
			bsel_pkg::ST_LC_MB: begin
				state_d = bsel_pkg::ST_LC_CMP;
			end
			bsel_pkg::ST_LC_CMP: begin
				state_d = last_s1 ? bsel_pkg::ST_FIN : bsel_pkg::ST_LC_RD;
			end
			bsel_pkg::ST_FIN: begin
				if (rsp_load) begin
					state_d = bsel_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bsel_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_ready = 1'b0;
		rd_en     = 1'b0;
		div_start = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			bsel_pkg::ST_IDLE: begin
				req_ready = 1'b1;
			end
			bsel_pkg::ST_SCAN: begin
				rd_en     = (iss_q < CNT_W'(NUM_SLOTS));
				div_start = scan_end && scan_have && (scan_total != '0);
			end
			bsel_pkg::ST_FIND: begin
				rd_en = (iss_q < CNT_W'(NUM_SLOTS));
			end
			bsel_pkg::ST_LC_RD: begin
				rd_en = 1'b1;
			end
			bsel_pkg::ST_FIN: begin
				rsp_load = !rsp_valid_q || rsp_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsel_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= bsel_pkg::MODE_WRR;
			limit_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bsel_pkg::CFG_ALGORITHM_MODE: begin
					mode_q <= cfg_data[0];
				end
				bsel_pkg::CFG_CONNECTION_LIMIT: begin
					limit_q <= cfg_data[bsel_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// table writes: drop a write aimed past the last slot
	assign wr_en   = accept && (req.op == bsel_pkg::OP_WRITE) && (32'(req.slot) < NUM_SLOTS);
	assign wr_addr = SLOT_W'(req.slot);
	assign wr_data = {req.healthy, WEIGHT_BITS'(req.weight), CONN_BITS'(req.connections)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (wr_en) begin
			entry_valid_q[wr_addr] <= req.valid_req;
		end
	end

	bsel_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (iss_q[SLOT_W-1:0]),
		.rdata (rd_data)
	);

	bsel_div #(
		.DIVIDEND_W (bsel_pkg::RR_W),
		.DIVISOR_W  (TOT_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (rr_q),
		.divisor   (total_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	// control: scan issue counter, stage-1 tag, round-robin counter, pick flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q       <= '0;
			act_s1      <= 1'b0;
			have_pick_q <= 1'b0;
			rr_q        <= '0;
		end else begin
			act_s1 <= rd_en;
			if (accept) begin
				iss_q       <= '0;
				have_pick_q <= 1'b0;
			end else if (rd_en) begin
				iss_q <= iss_q + CNT_W'(1);
			end else if (div_start) begin
				// restart the table walk for the cumulative search
				iss_q <= '0;
				rr_q  <= rr_q + bsel_pkg::RR_W'(1);
			end
			if ((state_q == bsel_pkg::ST_SCAN) && elig_s1) begin
				have_pick_q <= 1'b1;
			end
			if ((state_q == bsel_pkg::ST_LC_MA) && lc_take) begin
				have_pick_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= iss_q[SLOT_W-1:0];
			vld_s1 <= entry_valid_q[iss_q[SLOT_W-1:0]];
		end
		if (accept) begin
			total_q <= '0;
			cum_q   <= '0;
		end
		unique case (state_q)
			bsel_pkg::ST_SCAN: begin
				if (elig_s1) begin
					total_q <= total_sum;
					if (!have_pick_q) begin
						pick_q <= idx_s1;
					end
				end
			end
			bsel_pkg::ST_FIND: begin
				if (elig_s1) begin
					cum_q <= cum_sum;
					if (find_hit) begin
						pick_q <= idx_s1;
					end
				end
			end
			bsel_pkg::ST_LC_MA: begin
				if (lc_take) begin
					pick_q <= idx_s1;
					pw_q   <= cur_w;
					pc_q   <= cur_c;
				end
				if (lc_mul) begin
					prod_a_q <= mul_p;
				end
			end
			bsel_pkg::ST_LC_MB: begin
				prod_b_q <= mul_p;
			end
			bsel_pkg::ST_LC_CMP: begin
				if (lc_less) begin
					pick_q <= idx_s1;
					pw_q   <= cur_w;
					pc_q   <= cur_c;
				end
			end
			default: begin
			end
		endcase
	end

	// response register: load when free, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.found       <= have_pick_q;
			rsp_q.chosen_slot <= have_pick_q ? bsel_pkg::SLOT_FIELD_W'(pick_q) : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	// a finished result never overwrites one still waiting
	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bsel_pkg::ST_FIN && rsp_valid_q && !rsp_ready) |=>
		(state_q == bsel_pkg::ST_FIN))
		else $error("finished result overwrote a pending response");

	// round-robin counter only ever advances by one
	a_rr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(rr_q != $past(rr_q)) |-> (rr_q == $past(rr_q) + bsel_pkg::RR_W'(1)))
		else $error("round-robin counter jumped");

	// remainder unit reports only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == bsel_pkg::ST_DIV))
		else $error("divider finished outside the divide state");

	// the round-robin target always lies below the eligible weight total
	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bsel_pkg::ST_FIND) |-> (div_rem < total_q))
		else $error("round-robin target out of range");
`endif

endmodule
